// ----- src/cone_gradient_pixel_macros.svh -----
// Assertion macros for the conical gradient block.
// Used by modules in src; no other dependencies.
`ifndef CONE_GRADIENT_PIXEL_MACROS_SVH
`define CONE_GRADIENT_PIXEL_MACROS_SVH
`ifndef SYNTH
`define CGP_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("cgp check");
`define CGP_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("cgp check");
`else
`define CGP_ASSERT_IMP(label, clk, rst, a, c)
`define CGP_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ----- src/cgp_pkg.sv -----
// Package for the conical gradient block: widths, register indexes, CORDIC table.
// No dependencies.
package cgp_pkg;
  localparam int MaxWidth   = 4096;
  localparam int MaxHeight  = 4096;
  localparam int CordicSteps = 28;
  localparam int CoordW = 24;
  localparam int MultW  = 16;
  localparam int LevelW = 25;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 1;
  // Datapath width of the CORDIC x/y (25-bit vector scaled by 2^30 plus growth).
  localparam int CordW = 60;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ANTICLOCKWISE = 2'd0,
    REG_SYMMETRIC     = 2'd1,
    REG_USE_MULT      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic anticlockwise;
    logic symmetric;
    logic use_mult;
  } cfg_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0:  atan_turn = 32'd536870912;
      5'd1:  atan_turn = 32'd316933406;
      5'd2:  atan_turn = 32'd167458907;
      5'd3:  atan_turn = 32'd85004756;
      5'd4:  atan_turn = 32'd42667331;
      5'd5:  atan_turn = 32'd21354465;
      5'd6:  atan_turn = 32'd10679838;
      5'd7:  atan_turn = 32'd5340245;
      5'd8:  atan_turn = 32'd2670163;
      5'd9:  atan_turn = 32'd1335087;
      5'd10: atan_turn = 32'd667544;
      5'd11: atan_turn = 32'd333772;
      5'd12: atan_turn = 32'd166886;
      5'd13: atan_turn = 32'd83443;
      5'd14: atan_turn = 32'd41722;
      5'd15: atan_turn = 32'd20861;
      5'd16: atan_turn = 32'd10430;
      5'd17: atan_turn = 32'd5215;
      5'd18: atan_turn = 32'd2608;
      5'd19: atan_turn = 32'd1304;
      5'd20: atan_turn = 32'd652;
      5'd21: atan_turn = 32'd326;
      5'd22: atan_turn = 32'd163;
      5'd23: atan_turn = 32'd81;
      5'd24: atan_turn = 32'd41;
      5'd25: atan_turn = 32'd20;
      5'd26: atan_turn = 32'd10;
      5'd27: atan_turn = 32'd5;
      default: atan_turn = 32'd0;
    endcase
  endfunction
endpackage

// ----- src/cgp_if.sv -----
// Stream interfaces for the conical gradient block.
// Depends on cgp_pkg for field widths.
interface cgp_in_if import cgp_pkg::*; ();
  logic valid;
  logic ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic signed [CoordW-1:0] center_x;
  logic signed [CoordW-1:0] center_y;
  logic signed [CoordW-1:0] ref_x;
  logic signed [CoordW-1:0] ref_y;
  logic signed [MultW-1:0] multiplier;
  modport source (output valid, pixel_x, pixel_y, center_x, center_y, ref_x, ref_y,
                  multiplier, input ready);
  modport sink (input valid, pixel_x, pixel_y, center_x, center_y, ref_x, ref_y,
                multiplier, output ready);
endinterface

interface cgp_out_if import cgp_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [LevelW-1:0] level;
  modport source (output valid, level, input ready);
  modport sink (input valid, level, output ready);
endinterface

// ----- src/cgp_cordic.sv -----
// Pipelined CORDIC vectoring unit: one stage per iteration, angle as turn fraction.
// Depends on cgp_pkg. Advances when en is high; carries a sideband word.
module cgp_cordic import cgp_pkg::*; #(
  parameter int SideW = 1
) (
  input  logic clk,
  input  logic en,
  input  logic signed [CoordW:0] vx,
  input  logic signed [CoordW:0] vy,
  input  logic [SideW-1:0] side_in,
  output logic [31:0] angle,
  output logic [SideW-1:0] side_out
);
  logic signed [CordW-1:0] xs [CordicSteps+1];
  logic signed [CordW-1:0] ys [CordicSteps+1];
  logic [31:0] zs [CordicSteps+1];
  logic zero [CordicSteps+1];
  logic [SideW-1:0] sd [CordicSteps+1];

  // Prescale and half-turn for negative x.
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (vx == '0) && (vy == '0);
      sd[0] <= side_in;
      if (vx < 0) begin
        xs[0] <= -(CordW'(vx) <<< 30);
        ys[0] <= -(CordW'(vy) <<< 30);
        zs[0] <= 32'h8000_0000;
      end else begin
        xs[0] <= CordW'(vx) <<< 30;
        ys[0] <= CordW'(vy) <<< 30;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        sd[i+1] <= sd[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_turn(5'(i));
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_turn(5'(i));
        end
      end
    end
  end

  assign angle = zero[CordicSteps] ? 32'd0 : zs[CordicSteps];
  assign side_out = sd[CordicSteps];
endmodule

// ----- src/cone_gradient_pixel.sv -----
// Conical gradient pixel generator, top level.
// An accepted pixel passes stage 0, the CORDIC prescale and step stages, then stages A, B and C.
// Throughput: one pixel per cycle while not stalled; the CORDIC pipelines, 28 step stages each, set the depth.
// A stall freezes the whole pipeline; the output register stays valid until taken.
// Synchronous active-high rst clears valid bits and the three mode registers to 0.
`include "cone_gradient_pixel_macros.svh"
module cone_gradient_pixel import cgp_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidth,
  parameter int MAX_HEIGHT = MaxHeight
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  cgp_in_if.sink  in_s,
  cgp_out_if.source out_s
);
  localparam int Depth = CordicSteps + 5;
  localparam logic [16:0] WLim = 17'(MAX_WIDTH - 1);
  localparam logic [16:0] HLim = 17'(MAX_HEIGHT - 1);
  localparam int SideW = 1 + MultW;

  cfg_t cfg;
  logic en;
  logic [Depth-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ANTICLOCKWISE: cfg.anticlockwise <= cfg_data[0];
        REG_SYMMETRIC:     cfg.symmetric <= cfg_data[0];
        REG_USE_MULT:      cfg.use_mult <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output slot is free or being emptied.
  assign en = !vld[Depth-1] || out_s.ready;
  assign in_s.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_s.valid};
    end
  end

  // Stage 0: clamp and form vectors.
  logic signed [CoordW:0] pdx, pdy, rdx, rdy;
  logic s0_center;
  logic signed [MultW-1:0] s0_mult;
  logic [16:0] pxc, pyc;

  always_comb begin
    pxc = ({5'd0, in_s.pixel_x} > WLim) ? WLim : {5'd0, in_s.pixel_x};
    pyc = ({5'd0, in_s.pixel_y} > HLim) ? HLim : {5'd0, in_s.pixel_y};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pdx <= $signed({1'b0, pxc[11:0], 8'd0}) - (CoordW+1)'(in_s.center_x);
      pdy <= $signed({1'b0, pyc[11:0], 8'd0}) - (CoordW+1)'(in_s.center_y);
      rdx <= (CoordW+1)'(in_s.ref_x) - (CoordW+1)'(in_s.center_x);
      rdy <= (CoordW+1)'(in_s.ref_y) - (CoordW+1)'(in_s.center_y);
      s0_mult <= in_s.multiplier;
    end
  end
  assign s0_center = (pdx == '0) && (pdy == '0);

  logic [31:0] pang, rang;
  logic [SideW-1:0] side_p;
  logic [0:0] side_r;

  cgp_cordic #(.SideW(SideW)) u_pix (
    .clk, .en, .vx(pdx), .vy(pdy), .side_in({s0_center, s0_mult}),
    .angle(pang), .side_out(side_p)
  );
  cgp_cordic #(.SideW(1)) u_ref (
    .clk, .en, .vx(rdx), .vy(rdy), .side_in(1'b0),
    .angle(rang), .side_out(side_r)
  );

  // Stage A: angle difference, inversion, multiplier select.
  logic signed [33:0] t_a;
  logic ctr_a, ctr_b, ctr_c;
  logic signed [MultW-1:0] m_a;
  logic signed [49:0] p_b;
  logic signed [LevelW-1:0] lvl_c;
  logic [31:0] a_diff;

  assign a_diff = pang - rang;

  always_ff @(posedge clk) begin
    if (en) begin
      t_a <= cfg.anticlockwise ? 34'sd4294967296 - $signed({2'b0, a_diff})
                               : $signed({2'b0, a_diff});
      ctr_a <= side_p[SideW-1] | side_r[0] & 1'b0;
      m_a <= cfg.use_mult ? side_p[MultW-1:0] : 16'sd256;
    end
  end

  // Stage B: multiply.
  always_ff @(posedge clk) begin
    if (en) begin
      p_b <= 50'(t_a) * 50'(m_a);
      ctr_b <= ctr_a;
    end
  end

  // Stage C: fold (symmetric) or round and saturate; centre pixels get a fixed level.
  logic [40:0] w_f;
  logic [40:0] w_m;
  logic [17:0] w_r;
  logic signed [49:0] pr;
  logic signed [25:0] q;
  logic signed [LevelW-1:0] lvl_next;

  always_comb begin
    w_f = {p_b[39:0], 1'b0};
    w_m = (w_f > 41'h100_0000_0000) ? (41'd0 - w_f) : w_f;
    w_r = 18'((42'(w_m) + 42'd8388608) >> 24);
    pr = p_b + 50'sd8388608;
    q = 26'(pr >>> 24);
    if (ctr_b) begin
      lvl_next = 25'sd32768;
    end else if (cfg.symmetric) begin
      lvl_next = $signed({7'd0, w_r});
    end else if ((pr >>> 24) > 50'sd16777215) begin
      lvl_next = 25'sd16777215;
    end else if ((pr >>> 24) < -50'sd16777216) begin
      lvl_next = -25'sd16777216;
    end else begin
      lvl_next = q[LevelW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lvl_c <= lvl_next;
      ctr_c <= ctr_b;
    end
  end

  assign out_s.valid = vld[Depth-1];
  assign out_s.level = lvl_c;

  `CGP_ASSERT_NXT(a_hold, clk, rst, out_s.valid && !out_s.ready, out_s.valid && $stable(out_s.level))
  `CGP_ASSERT_IMP(a_center, clk, rst, out_s.valid && ctr_c, out_s.level == 25'sd32768)
  `CGP_ASSERT_IMP(a_ready, clk, rst, !out_s.valid, in_s.ready)
endmodule

// ----- tb/sv/cgp_checker.sv -----
// Checker for the conical gradient block: predicts each level from the accepted pixel
// transactions and compares it with the output channel. Depends on cgp_pkg and cgp_if.
module cgp_checker import cgp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  cgp_in_if in_m,
  cgp_out_if out_m,
  output int fail_count,
  output int pending_levels
);
  localparam logic [31:0] TurnTable [28] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5};

  logic mode_anti, mode_sym, mode_mult;
  logic signed [LevelW-1:0] level_queue[$];

  // Vector angle as a 32-bit fraction of a full turn.
  function automatic logic [31:0] vector_turns(input longint vx, input longint vy);
    longint x, y, xs, ys;
    logic [31:0] z;
    z = 32'd0;
    if (vx == 0 && vy == 0) return 32'd0;
    x = vx * 64'sd1073741824;
    y = vy * 64'sd1073741824;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 28; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + TurnTable[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - TurnTable[i];
      end
    end
    return z;
  endfunction

  function automatic logic signed [LevelW-1:0] gradient_level(
      input logic [11:0] px, input logic [11:0] py,
      input logic signed [CoordW-1:0] cx, input logic signed [CoordW-1:0] cy,
      input logic signed [CoordW-1:0] rx, input logic signed [CoordW-1:0] ry,
      input logic signed [MultW-1:0] mult);
    longint dx, dy, m, t, p, lvl;
    logic [31:0] a;
    logic [63:0] w;
    dx = longint'({52'd0, px}) * 256 - longint'(cx);
    dy = longint'({52'd0, py}) * 256 - longint'(cy);
    if (dx == 0 && dy == 0) return 25'sd32768;
    m = mode_mult ? longint'(mult) : 256;
    a = vector_turns(dx, dy) - vector_turns(longint'(rx) - longint'(cx),
                                            longint'(ry) - longint'(cy));
    t = longint'({32'd0, a});
    if (mode_anti) t = 64'sd4294967296 - t;
    p = t * m;
    if (mode_sym) begin
      w = (p << 1) & ((64'd1 << 41) - 1);
      if (w > (64'd1 << 40)) w = (64'd1 << 41) - w;
      lvl = longint'((w + (64'd1 << 23)) >> 24);
    end else begin
      lvl = (p + (64'sd1 << 23)) >>> 24;
    end
    if (lvl > 16777215) lvl = 16777215;
    if (lvl < -16777216) lvl = -16777216;
    return lvl[LevelW-1:0];
  endfunction

  assign pending_levels = level_queue.size();

  always @(posedge clk) begin
    if (rst) begin
      mode_anti <= 1'b0;
      mode_sym <= 1'b0;
      mode_mult <= 1'b0;
      fail_count <= 0;
      level_queue.delete();
    end else begin
      if (in_m.valid && in_m.ready)
        level_queue.push_back(gradient_level(in_m.pixel_x, in_m.pixel_y, in_m.center_x,
          in_m.center_y, in_m.ref_x, in_m.ref_y, in_m.multiplier));
      if (out_m.valid && out_m.ready) begin
        if (level_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected level %0d", out_m.level);
          fail_count <= fail_count + 1;
        end else begin
          logic signed [LevelW-1:0] want;
          want = level_queue.pop_front();
          if (want !== out_m.level) begin
            if (fail_count < 10)
              $display("level mismatch: expected %0d actual %0d", want, out_m.level);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ANTICLOCKWISE: mode_anti <= cfg_data[0];
          REG_SYMMETRIC: mode_sym <= cfg_data[0];
          REG_USE_MULT: mode_mult <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- tb/sv/tb_cone_gradient_pixel.sv -----
// Testbench top for the conical gradient block: drives pixel transactions, mode
// writes and output back-pressure. Depends on cgp_pkg, cgp_if, cgp_checker and cone_gradient_pixel.
module tb_cone_gradient_pixel;
  import cgp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int fail_count, pending_levels;
  int idle_cycles = 0;
  logic long_hold = 1'b0;

  cgp_in_if pix_ch();
  cgp_out_if lvl_ch();

  cone_gradient_pixel uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_s(pix_ch.sink), .out_s(lvl_ch.source)
  );

  cgp_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_m(pix_ch), .out_m(lvl_ch), .fail_count(fail_count), .pending_levels(pending_levels)
  );

  always #1 clk = ~clk;

  initial begin
    pix_ch.valid = 1'b0;
    pix_ch.pixel_x = '0;
    pix_ch.pixel_y = '0;
    pix_ch.center_x = '0;
    pix_ch.center_y = '0;
    pix_ch.ref_x = '0;
    pix_ch.ref_y = '0;
    pix_ch.multiplier = '0;
    lvl_ch.ready = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        lvl_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold <= 1'b0;
      end
      gap = pick_gap();
      if (gap == 0 || $urandom_range(0, 3) == 0) begin
        lvl_ch.ready <= 1'b1;
      end else begin
        lvl_ch.ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((pix_ch.valid && pix_ch.ready) || (lvl_ch.valid && lvl_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_pixel(input logic [11:0] px, input logic [11:0] py,
      input logic [23:0] cx, input logic [23:0] cy, input logic [23:0] rx,
      input logic [23:0] ry, input logic [15:0] mult);
    int gap;
    pix_ch.valid <= 1'b1;
    pix_ch.pixel_x <= px;
    pix_ch.pixel_y <= py;
    pix_ch.center_x <= cx;
    pix_ch.center_y <= cy;
    pix_ch.ref_x <= rx;
    pix_ch.ref_y <= ry;
    pix_ch.multiplier <= mult;
    do @(posedge clk); while (!pix_ch.ready);
    gap = long_hold ? 0 : pick_gap();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_modes(input logic anti, input logic sym, input logic mult);
    // Stop offering and let the last accepted transaction reach the checker.
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_levels != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_ANTICLOCKWISE;
    cfg_data <= anti;
    @(posedge clk);
    cfg_index <= REG_SYMMETRIC;
    cfg_data <= sym;
    @(posedge clk);
    cfg_index <= REG_USE_MULT;
    cfg_data <= mult;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_pixel();
    logic [11:0] px, py;
    logic [23:0] cx, cy, rx, ry;
    int kind;
    px = 12'($urandom);
    py = 12'($urandom);
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // Centre and reference inside the frame, the usual case.
      cx = 24'($urandom_range(0, 1048575));
      cy = 24'($urandom_range(0, 1048575));
      rx = 24'($urandom_range(0, 1048575));
      ry = 24'($urandom_range(0, 1048575));
    end else begin
      cx = 24'($urandom);
      cy = 24'($urandom);
      rx = 24'($urandom);
      ry = 24'($urandom);
    end
    if ($urandom_range(0, 15) == 0) begin
      cx = {px, 8'd0};
      cy = {py, 8'd0};
    end
    if ($urandom_range(0, 15) == 0) begin
      rx = cx;
      ry = cy;
    end
    send_pixel(px, py, cx, cy, rx, ry, 16'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_modes(1'b0, 1'b0, 1'b1);
    send_pixel(12'd0, 12'd0, 24'd0, 24'd0, 24'd256, 24'd0, 16'h7fff);
    send_pixel(12'd4095, 12'd4095, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 16'h8000);
    send_pixel(12'd4095, 12'd0, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 16'h0000);
    send_pixel(12'd10, 12'd20, 24'd2560, 24'd5120, 24'd0, 24'd0, 16'h0100);
    send_pixel(12'd5, 12'd5, 24'd100, 24'd100, 24'd100, 24'd100, 16'h0100);
    send_pixel(12'd0, 12'd100, 24'd25600, 24'd0, 24'd0, 24'd0, 16'hff00);
    set_modes(1'b1, 1'b1, 1'b1);
    send_pixel(12'd0, 12'd0, 24'd0, 24'd0, 24'd256, 24'd0, 16'h7fff);
    send_pixel(12'd4095, 12'd4095, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000, 16'h8000);
    send_pixel(12'd7, 12'd9, 24'd1792, 24'd2304, 24'd0, 24'd0, 16'h0100);
    send_pixel(12'd100, 12'd0, 24'd0, 24'd0, 24'd0, 24'd0, 16'h0300);
    send_pixel(12'd0, 12'd4095, 24'd512, 24'd512, 24'd512, 24'd0, 16'hfe80);
    set_modes(1'b0, 1'b1, 1'b0);
    send_pixel(12'd300, 12'd1, 24'd0, 24'd0, 24'd256, 24'd256, 16'h1234);
    send_pixel(12'd1, 12'd300, 24'd0, 24'd0, 24'd256, 24'd256, 16'h8000);

    for (int phase = 0; phase < 8; phase++) begin
      set_modes(phase[0], phase[1], phase[2]);
      // The long hold-off starts while pixels are offered, so the block fills up.
      if (phase == 0) long_hold <= 1'b1;
      for (int n = 0; n < 112; n++) random_pixel();
    end

    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_levels != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_levels == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- cone_gradient_pixel.f -----
+incdir+src
src/cgp_pkg.sv
src/cgp_if.sv
src/cgp_cordic.sv
src/cone_gradient_pixel.sv
tb/sv/cgp_checker.sv
tb/sv/tb_cone_gradient_pixel.sv
